// ===== design/rxf_pkg.sv =====
package rxf_pkg;

    // FIFO geometry.
    localparam int DEPTH = 64;
    localparam int PTR_W = $clog2(DEPTH);
    // The count never exceeds DEPTH-1, so it fits in the pointer width.
    localparam int CNT_W = $clog2(DEPTH);

    // Field widths fixed by the interface.
    localparam int BYTE_W  = 8;
    localparam int LEVEL_W = 6;
    localparam int FILL_W  = 6;
    // Width at which the count and the levels are compared.
    localparam int CMP_W   = (CNT_W > LEVEL_W) ? CNT_W : LEVEL_W;

    // Configuration port geometry.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [FILL_W-1:0]  fill_t;
    typedef logic [PTR_W-1:0]   ptr_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [REG_IDX_W-1:0] reg_idx_t;

    // Register map.
    localparam reg_idx_t REG_ALMOST_FULL  = reg_idx_t'(0);
    localparam reg_idx_t REG_ALMOST_EMPTY = reg_idx_t'(1);

    localparam level_t ALMOST_FULL_RESET  = level_t'(40);
    localparam level_t ALMOST_EMPTY_RESET = level_t'(10);

    // Flow-control characters.
    localparam byte_t CHAR_XOFF     = 8'h13;
    localparam byte_t CHAR_XON      = 8'h11;
    localparam byte_t CHAR_OVERFLOW = 8'h56;

    // Command field codes.
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef struct packed {
        level_t almost_full;
        level_t almost_empty;
    } cfg_levels_t;

    typedef enum logic [0:0] {
        CTL_IDLE,
        CTL_HOLD
    } ctl_state_t;

    typedef struct packed {
        logic capture;
        logic mem_write;
        logic push_ok;
        logic overflow;
        logic pop_ok;
    } ctl_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } dp_status_t;

endpackage

// ===== design/rxf_if.sv =====
interface rxf_in_if;
    logic              valid;
    logic              ready;
    logic              command;
    rxf_pkg::byte_t    rx_byte;

    modport source (output valid, output command, output rx_byte, input ready);
    modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

interface rxf_out_if;
    logic              valid;
    logic              ready;
    rxf_pkg::byte_t    read_data;
    logic              read_valid;
    logic              tx_valid;
    rxf_pkg::byte_t    tx_char;
    rxf_pkg::fill_t    fill_count;
    logic              paused_flag;

    modport source (output valid, output read_data, output read_valid, output tx_valid,
                    output tx_char, output fill_count, output paused_flag, input ready);
    modport sink   (input valid, input read_data, input read_valid, input tx_valid,
                    input tx_char, input fill_count, input paused_flag, output ready);
endinterface

// ===== design/rxf_cfg_regs.sv =====
module rxf_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rxf_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [rxf_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [rxf_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    output rxf_pkg::cfg_levels_t                levels
);
    import rxf_pkg::*;

    level_t   af_reg;
    level_t   af_next;
    level_t   ae_reg;
    level_t   ae_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = paddr[APB_ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        af_next = af_reg;
        ae_next = ae_reg;
        if (wr_en)
        begin
            case (idx)
                REG_ALMOST_FULL:  af_next = pwdata[LEVEL_W-1:0];
                REG_ALMOST_EMPTY: ae_next = pwdata[LEVEL_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            af_reg <= ALMOST_FULL_RESET;
            ae_reg <= ALMOST_EMPTY_RESET;
        end
        else
        begin
            af_reg <= af_next;
            ae_reg <= ae_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_ALMOST_FULL:  prdata = APB_DATA_W'(af_reg);
            REG_ALMOST_EMPTY: prdata = APB_DATA_W'(ae_reg);
            default:          prdata = '0;
        endcase
    end

    assign levels.almost_full  = af_reg;
    assign levels.almost_empty = ae_reg;

endmodule

// ===== design/rxf_ctrl.sv =====
module rxf_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_command,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  rxf_pkg::dp_status_t   status,
    output rxf_pkg::ctl_cmd_t     cmd
);
    import rxf_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;
    logic       accept;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CTL_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = CTL_HOLD;
                end
            end
            CTL_HOLD:
            begin
                if (out_ready)
                begin
                    state_next = CTL_IDLE;
                end
            end
            default: state_next = CTL_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Commands to the datapath for the item taken in this cycle.
    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            CTL_IDLE: in_ready  = 1'b1;
            CTL_HOLD: out_valid = 1'b1;
            default:  ;
        endcase
        accept        = in_valid && in_ready;
        cmd.capture   = accept;
        cmd.mem_write = accept && (in_command == CMD_PUSH);
        cmd.push_ok   = accept && (in_command == CMD_PUSH) && !status.full;
        cmd.overflow  = accept && (in_command == CMD_PUSH) && status.full;
        cmd.pop_ok    = accept && (in_command == CMD_POP) && !status.empty;
    end

endmodule

// ===== design/rxf_datapath.sv =====
module rxf_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rxf_pkg::ctl_cmd_t      cmd,
    input  rxf_pkg::byte_t         rx_byte,
    input  rxf_pkg::cfg_levels_t   levels,
    output rxf_pkg::dp_status_t    status,
    output rxf_pkg::byte_t         read_data,
    output logic                   read_valid,
    output logic                   tx_valid,
    output rxf_pkg::byte_t         tx_char,
    output rxf_pkg::fill_t         fill_count,
    output logic                   paused_flag
);
    import rxf_pkg::*;

    byte_t            mem [DEPTH];
    byte_t            mem_q_reg;

    ptr_t             wr_ptr_reg;
    ptr_t             wr_ptr_next;
    ptr_t             rd_ptr_reg;
    ptr_t             rd_ptr_next;
    cnt_t             count_reg;
    cnt_t             count_next;
    logic             paused_reg;
    logic             paused_next;

    logic             rvalid_reg;
    logic             rvalid_next;
    logic             txv_reg;
    logic             txv_next;
    byte_t            txc_reg;
    byte_t            txc_next;
    fill_t            fill_reg;
    fill_t            fill_next;
    logic             rpaused_reg;

    cnt_t             cnt_inc;
    cnt_t             cnt_dec;
    logic [CMP_W-1:0] cnt_ext;
    logic             xoff_hit;
    logic             xon_hit;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_W'(DEPTH - 1));

    assign cnt_inc  = count_reg + cnt_t'(1);
    assign cnt_dec  = count_reg - cnt_t'(1);
    assign xoff_hit = (CMP_W'(cnt_inc) == CMP_W'(levels.almost_full));
    assign xon_hit  = (CMP_W'(cnt_dec) == CMP_W'(levels.almost_empty)) && paused_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        paused_next = paused_reg;
        txv_next    = 1'b0;
        txc_next    = '0;
        rvalid_next = cmd.pop_ok;
        if (cmd.push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + ptr_t'(1);
            count_next  = cnt_inc;
            if (xoff_hit)
            begin
                txv_next    = 1'b1;
                txc_next    = CHAR_XOFF;
                paused_next = 1'b1;
            end
        end
        else if (cmd.overflow)
        begin
            txv_next = 1'b1;
            txc_next = CHAR_OVERFLOW;
        end
        else if (cmd.pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + ptr_t'(1);
            count_next  = cnt_dec;
            if (xon_hit)
            begin
                txv_next    = 1'b1;
                txc_next    = CHAR_XON;
                paused_next = 1'b0;
            end
        end
        cnt_ext   = CMP_W'(count_next);
        fill_next = cnt_ext[FILL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            paused_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            paused_reg <= paused_next;
        end
    end

    // Result register, loaded once per accepted item.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rvalid_reg  <= rvalid_next;
            txv_reg     <= txv_next;
            txc_reg     <= txc_next;
            fill_reg    <= fill_next;
            rpaused_reg <= paused_next;
        end
    end

    // Byte store with registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.mem_write)
        begin
            mem[wr_ptr_reg] <= rx_byte;
        end
        if (cmd.pop_ok)
        begin
            mem_q_reg <= mem[rd_ptr_reg];
        end
    end

    assign read_data   = rvalid_reg ? mem_q_reg : '0;
    assign read_valid  = rvalid_reg;
    assign tx_valid    = txv_reg;
    assign tx_char     = txc_reg;
    assign fill_count  = fill_reg;
    assign paused_flag = rpaused_reg;

endmodule

// ===== design/rx_fifo_with_xon_xoff_core.sv =====
// Receive FIFO with XON/XOFF software flow control.
// The cmd_ch channel carries one beat per operation: command selects a push of rx_byte
// or a pop of the oldest stored byte. The res_ch channel returns exactly one beat per
// operation with the popped byte, the flow-control character to transmit (Ctrl-S when
// the count reaches the almost-full level, Ctrl-Q when it falls to the almost-empty
// level while paused, 'V' when a push finds DEPTH-1 bytes held and is dropped), the
// fill count and the paused flag after the operation.
// Timing: an operation beat accepted at one clock edge produces its result beat in the
// next cycle. The block takes one operation at a time and accepts no new operation until
// the result of the last one has been taken; the controller raises cmd_ch ready only
// in the cycle after the single result register has been taken.
// If the receiver stalls, the result beat holds steady and cmd_ch ready stays low until
// the result is taken. Nothing is lost or repeated.
// The two level registers sit on the APB port at byte addresses 0 (almost full) and 4
// (almost empty); pready is always high. Change them only while the block is idle.
// Reset clears the pointers, count and paused flag and restores the levels to 40 and
// 10. The byte store is not cleared; only written entries are ever read back.
module rx_fifo_with_xon_xoff_core (
    input  logic                                clk,
    input  logic                                rst_n,
    rxf_in_if.sink                              cmd_ch,
    rxf_out_if.source                           res_ch,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rxf_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [rxf_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [rxf_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import rxf_pkg::*;

    cfg_levels_t levels;
    ctl_cmd_t    cmd;
    dp_status_t  status;

    // Level registers behind the configuration port.
    rxf_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .levels  (levels)
    );

    // Handshake control: accepts an operation when idle, then holds the result
    // until the receiver takes it.
    rxf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (cmd_ch.valid),
        .in_command (cmd_ch.command),
        .in_ready   (cmd_ch.ready),
        .out_valid  (res_ch.valid),
        .out_ready  (res_ch.ready),
        .status     (status),
        .cmd        (cmd)
    );

    // Byte store, pointers, count, threshold compares and the result register.
    rxf_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .rx_byte     (cmd_ch.rx_byte),
        .levels      (levels),
        .status      (status),
        .read_data   (res_ch.read_data),
        .read_valid  (res_ch.read_valid),
        .tx_valid    (res_ch.tx_valid),
        .tx_char     (res_ch.tx_char),
        .fill_count  (res_ch.fill_count),
        .paused_flag (res_ch.paused_flag)
    );

endmodule

// ===== dv/rxf_flow_check.sv =====
`timescale 1ns / 1ps

// Watches the operation and result channels and the APB level writes, keeps its own copy
// of the FIFO and the flow-control state, and compares every result beat with the
// oldest predicted one.
module rxf_flow_check (
    input  logic                           clk,
    input  logic                           rst_n,
    rxf_in_if                              cmd_ch,
    rxf_out_if                             res_ch,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [rxf_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rxf_pkg::APB_DATA_W-1:0] pwdata,
    output int                             outstanding,
    output int                             error_count,
    output int                             overflow_drops,
    output int                             xoff_sent,
    output int                             xon_sent,
    output int                             empty_pops
);
    import rxf_pkg::*;

    typedef struct packed {
        byte_t read_data;
        logic  read_valid;
        logic  tx_valid;
        byte_t tx_char;
        fill_t fill_count;
        logic  paused_flag;
    } fifo_result_t;

    byte_t        byte_model [DEPTH];
    ptr_t         wr_ptr;
    ptr_t         rd_ptr;
    int           held;
    logic         paused_now;
    level_t       full_level;
    level_t       empty_level;
    fifo_result_t pending_results [$];

    function automatic ptr_t next_ptr(input ptr_t p);
        return (int'(p) == DEPTH - 1) ? ptr_t'(0) : ptr_t'(p + 1'b1);
    endfunction

    // Applies one operation to the FIFO copy and returns the result beat it must produce.
    function automatic fifo_result_t apply_op(input logic cmd, input byte_t data);
        fifo_result_t r;
        r = '0;
        if (cmd == CMD_PUSH) begin
            // The slot is written even when the push is dropped.
            byte_model[wr_ptr] = data;
            if (held >= DEPTH - 1) begin
                r.tx_valid = 1'b1;
                r.tx_char  = CHAR_OVERFLOW;
                overflow_drops++;
            end else begin
                wr_ptr = next_ptr(wr_ptr);
                held++;
                if (held == int'(full_level)) begin
                    r.tx_valid = 1'b1;
                    r.tx_char  = CHAR_XOFF;
                    paused_now = 1'b1;
                    xoff_sent++;
                end
            end
        end else if (held != 0) begin
            r.read_data  = byte_model[rd_ptr];
            r.read_valid = 1'b1;
            rd_ptr = next_ptr(rd_ptr);
            held--;
            if (held == int'(empty_level) && paused_now) begin
                r.tx_valid = 1'b1;
                r.tx_char  = CHAR_XON;
                paused_now = 1'b0;
                xon_sent++;
            end
        end else begin
            empty_pops++;
        end
        r.fill_count  = fill_t'(held);
        r.paused_flag = paused_now;
        return r;
    endfunction

    // Every mismatch is counted and reported.
    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            error_count++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        fifo_result_t want;
        fifo_result_t got;
        if (!rst_n)
        begin
            wr_ptr         = '0;
            rd_ptr         = '0;
            held           = 0;
            paused_now     = 1'b0;
            full_level     = ALMOST_FULL_RESET;
            empty_level    = ALMOST_EMPTY_RESET;
            pending_results.delete();
            outstanding    = 0;
            error_count    = 0;
            overflow_drops = 0;
            xoff_sent      = 0;
            xon_sent       = 0;
            empty_pops     = 0;
        end
        else
        begin
            // Results are compared before new predictions go in, so a result beat can
            // never be matched with the operation accepted at the same edge.
            if (res_ch.valid && res_ch.ready)
            begin
                got.read_data   = res_ch.read_data;
                got.read_valid  = res_ch.read_valid;
                got.tx_valid    = res_ch.tx_valid;
                got.tx_char     = res_ch.tx_char;
                got.fill_count  = res_ch.fill_count;
                got.paused_flag = res_ch.paused_flag;
                if (pending_results.size() == 0)
                begin
                    error_count++;
                    $error("result beat with no operation outstanding");
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("read_data", want.read_data, got.read_data);
                    check_field("read_valid", 8'(want.read_valid), 8'(got.read_valid));
                    check_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
                    check_field("tx_char", want.tx_char, got.tx_char);
                    check_field("fill_count", 8'(want.fill_count), 8'(got.fill_count));
                    check_field("paused_flag", 8'(want.paused_flag), 8'(got.paused_flag));
                end
            end
            if (cmd_ch.valid && cmd_ch.ready)
                pending_results.push_back(apply_op(cmd_ch.command, cmd_ch.rx_byte));
            if (psel && penable && pwrite && pready)
            begin
                if (reg_idx_t'(paddr >> 2) == REG_ALMOST_FULL)
                    full_level = level_t'(pwdata);
                else if (reg_idx_t'(paddr >> 2) == REG_ALMOST_EMPTY)
                    empty_level = level_t'(pwdata);
            end
            outstanding = pending_results.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

// Top of the receive FIFO test. This module only makes stimulus and gives the verdict;
// prediction and comparison live in the flow checker instantiated beside the block.
//
// The run starts with a short directed part (empty pops, byte extremes, pause and resume
// at tiny levels, a repeated pause, unreachable levels) and then goes through a series
// of level settings. In each setting the operations come in segments with a random push
// bias, so the FIFO is filled to overflow, drained to empty and held in between.
module testbench;
    import rxf_pkg::*;

    localparam int PHASES     = 8;
    localparam int PHASE_OPS  = 170;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    rxf_in_if  cmd_ch ();
    rxf_out_if res_ch ();

    int outstanding;
    int error_count;
    int overflow_drops;
    int xoff_sent;
    int xon_sent;
    int empty_pops;

    // Sender burst bookkeeping: beats left in the current burst and beats sent so far.
    int burst_left;
    int ops_sent;
    int settings_used;

    rx_fifo_with_xon_xoff_core i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd_ch  (cmd_ch),
        .res_ch  (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    rxf_flow_check u_flow_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_ch         (cmd_ch),
        .res_ch         (res_ch),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .outstanding    (outstanding),
        .error_count    (error_count),
        .overflow_drops (overflow_drops),
        .xoff_sent      (xoff_sent),
        .xon_sent       (xon_sent),
        .empty_pops     (empty_pops)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit on the run. The slowest correct run, with every beat hitting the longest
    // sender gap and the longest receiver stall, stays well under a tenth of this.
    initial
    begin
        #(5_000_000);
        $display("testbench: errors");
        $finish;
    end

    // The receiver runs through stretches of its own: always ready, ready at random, a
    // regular one-in-eight stall, and a long stall followed by a ready stretch.
    initial
    begin
        int mode;
        int len;
        int k;
        res_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(5, 60);
            for (k = 0; k < len; k++)
            begin
                case (mode)
                    0: res_ch.ready <= 1'b1;
                    1: res_ch.ready <= 1'($urandom_range(0, 1));
                    2: res_ch.ready <= ((k % 8) != 7);
                    default: res_ch.ready <= (k >= len / 3);
                endcase
                @(posedge clk);
            end
        end
    end

    // Sends one operation beat and waits for it to be taken. valid stays high into the
    // next beat of a burst; at the end of a burst the sender drops valid for a random gap
    // with junk on the payload and picks the length of the next burst.
    task automatic send_op(input logic cmd, input byte_t data);
        int gap;
        cmd_ch.valid   <= 1'b1;
        cmd_ch.command <= cmd;
        cmd_ch.rx_byte <= data;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        ops_sent++;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            cmd_ch.valid   <= 1'b0;
            cmd_ch.command <= 1'($urandom);
            cmd_ch.rx_byte <= byte_t'($urandom);
            repeat (gap) @(posedge clk);
            // Now and then a long burst gives a stretch with no sender idling at all.
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 200)
                                                     : $urandom_range(0, 20);
        end
        else
        begin
            burst_left--;
        end
    endtask

    // Holds the sender off until every outstanding result beat has been taken. The
    // outstanding count is updated at the rising edge, so it is looked at on the falling
    // edge.
    task automatic wait_idle();
        cmd_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (3) @(posedge clk);
    endtask

    // One APB write: a setup cycle, then the access cycle that completes with pready.
    // The upper data bits carry junk; only the low six bits form the level.
    task automatic write_level(input reg_idx_t idx, input level_t level);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx) << 2;
        pwdata  <= ($urandom & ~32'h3F) | APB_DATA_W'(level);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Both levels are changed only once the block has returned every result.
    task automatic set_levels(input level_t full_lvl, input level_t empty_lvl);
        wait_idle();
        write_level(REG_ALMOST_FULL, full_lvl);
        write_level(REG_ALMOST_EMPTY, empty_lvl);
        settings_used++;
    endtask

    // Random operations in segments. Each segment has its own push bias, from a pure
    // fill that runs into overflow down to a near-pure drain that ends in empty pops.
    task automatic run_phase(input int n_ops, input bit mid_pause);
        int done;
        int seg_len;
        int push_pct;
        int i;
        logic cmd;
        done = 0;
        while (done < n_ops)
        begin
            seg_len = $urandom_range(10, 80);
            case ($urandom_range(0, 5))
                0: push_pct = 100;
                1: push_pct = 90;
                2: push_pct = 70;
                3: push_pct = 50;
                4: push_pct = 25;
                default: push_pct = 5;
            endcase
            for (i = 0; i < seg_len && done < n_ops; i++)
            begin
                cmd = ($urandom_range(1, 100) <= push_pct) ? CMD_PUSH : CMD_POP;
                send_op(cmd, byte_t'($urandom));
                done++;
                if (mid_pause && done == n_ops / 2)
                    wait_idle();
            end
        end
    endtask

    initial
    begin
        int p;
        level_t full_lvl;
        level_t empty_lvl;
        burst_left    = 0;
        ops_sent      = 0;
        settings_used = 0;
        rst_n          <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.command <= CMD_PUSH;
        cmd_ch.rx_byte <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset levels: an empty pop, both byte extremes through the FIFO, empty again.
        send_op(CMD_POP, 8'hA5);
        send_op(CMD_PUSH, 8'h00);
        send_op(CMD_PUSH, 8'hFF);
        send_op(CMD_POP, 8'h3C);
        send_op(CMD_POP, 8'hC3);
        send_op(CMD_POP, 8'hFF);

        // Tiny levels: pause at two bytes, a second pause while already paused, and a
        // resume when the FIFO drains to empty.
        set_levels(level_t'(2), level_t'(0));
        send_op(CMD_PUSH, 8'h55);
        send_op(CMD_PUSH, 8'hAA);
        send_op(CMD_PUSH, 8'h01);
        send_op(CMD_POP, 8'h00);
        send_op(CMD_POP, 8'h00);
        send_op(CMD_PUSH, 8'h7F);
        send_op(CMD_POP, 8'h00);
        send_op(CMD_POP, 8'h00);

        // Lowest reachable pause level: every push pauses, every pop resumes.
        set_levels(level_t'(1), level_t'(0));
        send_op(CMD_PUSH, 8'h80);
        send_op(CMD_POP, 8'hFF);

        // Levels that the count can never match: no pause or resume is sent.
        set_levels(level_t'(0), level_t'(63));
        send_op(CMD_PUSH, 8'hFE);
        send_op(CMD_PUSH, 8'h01);
        send_op(CMD_POP, 8'h00);
        send_op(CMD_POP, 8'h00);
        send_op(CMD_POP, 8'h00);

        // Random part, one level setting per phase. The first six cover the extremes and
        // an inverted pair; the last two are drawn at random over the full register range.
        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0: begin full_lvl = level_t'(62); empty_lvl = level_t'(0);  end
                1: begin full_lvl = level_t'(1);  empty_lvl = level_t'(62); end
                2: begin full_lvl = level_t'(63); empty_lvl = level_t'(63); end
                3: begin full_lvl = level_t'(0);  empty_lvl = level_t'(5);  end
                4: begin full_lvl = ALMOST_FULL_RESET; empty_lvl = ALMOST_EMPTY_RESET; end
                5: begin full_lvl = level_t'(20); empty_lvl = level_t'(30); end
                default:
                begin
                    full_lvl  = level_t'($urandom_range(0, 63));
                    empty_lvl = level_t'($urandom_range(0, 63));
                end
            endcase
            set_levels(full_lvl, empty_lvl);
            // One phase also holds the sender off in the middle until all results are in.
            run_phase(PHASE_OPS, p == 3);
        end

        wait_idle();
        repeat (10) @(posedge clk);

        $display("Run covered %0d operations over %0d level settings, %0d empty pops.",
                 ops_sent, settings_used, empty_pops);
        $display("Flow control seen: %0d pauses, %0d resumes, %0d dropped overflow pushes.",
                 xoff_sent, xon_sent, overflow_drops);
        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
